[rtl/rfua_pkg.sv]
// shared types and constants for the rtp h.264 fu-a packetizer
// no dependencies; imported by every module of the block
package rfua_pkg;

   localparam int MaxFrameBytesDefault = 524288;
   localparam int QueueDepth           = 4;

   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 32;

   // register indexes
   localparam logic [CsrIndexW-1:0] CSR_MAX_PAYLOAD      = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_PAYLOAD_TYPE     = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_STREAM_SOURCE_ID = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_TS_INCREMENT     = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_OVERRIDE_ENABLE  = 3'd4;
   localparam logic [CsrIndexW-1:0] CSR_OVERRIDE_VALUE   = 3'd5;

   // register reset values
   localparam logic [10:0] RST_MAX_PAYLOAD      = 11'd1400;
   localparam logic [6:0]  RST_PAYLOAD_TYPE     = 7'd96;
   localparam logic [31:0] RST_STREAM_SOURCE_ID = 32'd10;
   localparam logic [31:0] RST_TS_INCREMENT     = 32'd3600;
   localparam logic        RST_OVERRIDE_ENABLE  = 1'b1;
   localparam logic [7:0]  RST_OVERRIDE_VALUE   = 8'd3;

   localparam logic [10:0] PAYLOAD_MIN = 11'd16;
   localparam logic [10:0] PAYLOAD_MAX = 11'd1460;

   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [7:0] NRI_MASK         = 8'hE0;
   localparam logic [7:0] NAL_TYPE_MASK    = 8'h1F;
   localparam logic [7:0] FU_TYPE          = 8'd28;
   localparam logic [7:0] FU_START_BIT     = 8'h80;
   localparam logic [7:0] FU_END_BIT       = 8'h40;

   // byte positions inside a packet opening
   localparam int IdxW = 4;
   localparam logic [IdxW-1:0] IDX_FU_IND   = 4'd12;
   localparam logic [IdxW-1:0] IDX_FU_HDR   = 4'd13;
   localparam logic [IdxW-1:0] IDX_HDR_DATA = 4'd12;
   localparam logic [IdxW-1:0] IDX_FU_DATA  = 4'd14;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_of_frame;
      logic [18:0] frame_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [10:0] max_payload;
      logic [6:0]  payload_type;
      logic [31:0] stream_source_id;
      logic [31:0] ts_increment;
      logic        override_enable;
      logic [7:0]  override_value;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_DATA,   // payload byte only
      CMD_HDR,    // rtp header, then payload byte
      CMD_FU      // rtp header, fu indicator, fu header, then payload byte
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         marker;
      logic         pkt_end;
      logic [7:0]   data_byte;
      logic [15:0]  seq;
      logic [31:0]  ts;
      logic [7:0]   fu_ind;
      logic [7:0]   fu_hdr;
   } cmd_type;

endpackage

[rtl/rtp_h264_fua_packetizer.sv]
// top level of the rtp h.264 fu-a packetizer: config registers and the front/back split
// depends on rfua_pkg, rfua_front, rfua_cmd_queue, rfua_back
//
// takes one h.264 nal byte per beat and delivers the rtp byte stream, one byte per beat.
// a frame of at most max_payload bytes becomes one packet with the marker set; a longer
// frame becomes fu-a packets (its nal header byte gives no output). each byte that opens
// a packet gives 13 output beats (15 for an fu-a fragment), every other byte gives one,
// and run_last marks the last beat of each input byte. while the queue is not full the
// front accepts one byte per cycle and pushes a command into a 4-entry queue; the back
// turns one command beat per cycle, while the output is empty or popped, into output
// beats through a single output register, so the output side sets the pace: with the
// output never stalled the sustained input rate is one byte per cycle within a packet,
// and a packet header can hold the input off (full) while its beats go out. a byte
// passes the queue, then the output register. the user must write config registers only
// while the block is idle (not enforced); max_payload is sampled at each frame start.
module rtp_h264_fua_packetizer #(
   parameter int MAX_FRAME_BYTES = rfua_pkg::MaxFrameBytesDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input beats
   input  logic                                  push,
   output logic                                  full,
   input  rfua_pkg::req_type                     req_data,
   // result beats
   output logic                                  empty,
   input  logic                                  pop,
   output rfua_pkg::rsp_type                     rsp_data,
   // config write port
   input  logic                                  csr_we,
   input  logic [rfua_pkg::CsrIndexW-1:0]        csr_index,
   input  logic [rfua_pkg::CsrDataW-1:0]         csr_wdata
);
   import rfua_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    in_take;
   logic    cmd_push, cmd_full, cmd_valid, cmd_pop;
   cmd_type cmd_item, cmd_head;

   // config register file, written one field at a time
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_PAYLOAD:      cfg_in.max_payload      = csr_wdata[10:0];
            CSR_PAYLOAD_TYPE:     cfg_in.payload_type     = csr_wdata[6:0];
            CSR_STREAM_SOURCE_ID: cfg_in.stream_source_id = csr_wdata[31:0];
            CSR_TS_INCREMENT:     cfg_in.ts_increment     = csr_wdata[31:0];
            CSR_OVERRIDE_ENABLE:  cfg_in.override_enable  = csr_wdata[0];
            CSR_OVERRIDE_VALUE:   cfg_in.override_value   = csr_wdata[7:0];
            default:              cfg_in = cfg_ff;   // writes past the list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_payload      <= RST_MAX_PAYLOAD;
         cfg_ff.payload_type     <= RST_PAYLOAD_TYPE;
         cfg_ff.stream_source_id <= RST_STREAM_SOURCE_ID;
         cfg_ff.ts_increment     <= RST_TS_INCREMENT;
         cfg_ff.override_enable  <= RST_OVERRIDE_ENABLE;
         cfg_ff.override_value   <= RST_OVERRIDE_VALUE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // the front only stalls when the command queue has no room
   assign full    = cmd_full;
   assign in_take = push && !cmd_full;

   rfua_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_take  (in_take),
      .in_item  (req_data),
      .cmd_push (cmd_push),
      .cmd_item (cmd_item)
   );

   rfua_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_item (cmd_item),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .head      (cmd_head)
   );

   // back side reads header fields straight from config; the user keeps it stable while busy (not enforced)
   rfua_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .out_empty (empty),
      .out_pop   (pop),
      .out_item  (rsp_data)
   );

endmodule

[rtl/rfua_front.sv]
// front part: tracks frame and packet state per input byte and issues commands
// depends on rfua_pkg
module rfua_front #(
   parameter int MAX_FRAME_BYTES = rfua_pkg::MaxFrameBytesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  rfua_pkg::cfg_type cfg,
   input  logic              in_take,
   input  rfua_pkg::req_type in_item,
   output logic              cmd_push,
   output rfua_pkg::cmd_type cmd_item
);
   import rfua_pkg::*;

   localparam int LeftW = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CmpW  = (LeftW > 19) ? LeftW : 19;
   localparam logic [CmpW-1:0] MaxLen = CmpW'(MAX_FRAME_BYTES);

   logic [15:0]      seq_ff, seq_in;
   logic [31:0]      ts_ff, ts_in;
   logic [LeftW-1:0] left_ff, left_in;
   logic [10:0]      bip_ff, bip_in;
   logic             frag_ff, frag_in;
   logic [7:0]       fui_ff, fui_in;
   logic [7:0]       fuh_ff, fuh_in;
   logic [10:0]      limit_ff, limit_in;

   logic [CmpW-1:0]  len_cmp, len_sat_cmp;
   logic [LeftW-1:0] len_sat, left_dec;
   logic [10:0]      limit_new, bip_inc;
   logic             fits, last_frag, frag_end;
   logic [7:0]       fuh_e;

   always_comb begin
      len_cmp     = CmpW'(in_item.frame_length);
      len_sat_cmp = (len_cmp > MaxLen) ? MaxLen : len_cmp;
      len_sat     = LeftW'(len_sat_cmp);
      if (cfg.max_payload < PAYLOAD_MIN) begin
         limit_new = PAYLOAD_MIN;
      end else if (cfg.max_payload > PAYLOAD_MAX) begin
         limit_new = PAYLOAD_MAX;
      end else begin
         limit_new = cfg.max_payload;
      end
      fits      = len_sat_cmp <= CmpW'(limit_new);
      left_dec  = left_ff - LeftW'(1);
      last_frag = ((LeftW + 1)'(left_ff) + (LeftW + 1)'(2)) <= (LeftW + 1)'(limit_ff);
      fuh_e     = last_frag ? (fuh_ff | FU_END_BIT) : fuh_ff;
      bip_inc   = bip_ff + 11'd1;
      frag_end  = (left_dec == '0) || (bip_inc >= (limit_ff - 11'd2));

      seq_in   = seq_ff;
      ts_in    = ts_ff;
      left_in  = left_ff;
      bip_in   = bip_ff;
      frag_in  = frag_ff;
      fui_in   = fui_ff;
      fuh_in   = fuh_ff;
      limit_in = limit_ff;

      cmd_push          = 1'b0;
      cmd_item          = '0;
      cmd_item.kind     = CMD_DATA;
      cmd_item.data_byte = in_item.data_byte;
      cmd_item.seq      = seq_ff;

      if (in_take) begin
         if (in_item.first_of_frame) begin
            if (in_item.frame_length != '0) begin
               limit_in = limit_new;
               ts_in    = ts_ff + cfg.ts_increment;
               bip_in   = '0;
               left_in  = len_sat - LeftW'(1);
               if (fits) begin
                  // whole frame in one packet
                  frag_in          = 1'b0;
                  seq_in           = seq_ff + 16'd1;
                  cmd_push         = 1'b1;
                  cmd_item.kind    = CMD_HDR;
                  cmd_item.marker  = 1'b1;
                  cmd_item.pkt_end = (len_sat == LeftW'(1));
               end else begin
                  // nal header folds into fu indicator and fu header
                  frag_in = 1'b1;
                  fui_in  = (in_item.data_byte & NRI_MASK) | FU_TYPE;
                  fuh_in  = FU_START_BIT | (in_item.data_byte & NAL_TYPE_MASK);
               end
            end
         end else if (left_ff != '0) begin
            left_in  = left_dec;
            cmd_push = 1'b1;
            if (!frag_ff) begin
               cmd_item.pkt_end = (left_dec == '0);
            end else begin
               cmd_item.pkt_end = frag_end;
               bip_in           = frag_end ? 11'd0 : bip_inc;
               if (left_dec == '0) begin
                  frag_in = 1'b0;
               end
               if (bip_ff == '0) begin
                  cmd_item.kind   = CMD_FU;
                  cmd_item.marker = last_frag;
                  cmd_item.fu_ind = fui_ff;
                  cmd_item.fu_hdr = fuh_e;
                  seq_in          = seq_ff + 16'd1;
                  fuh_in          = fuh_e & ~FU_START_BIT;
               end
            end
         end
      end
      cmd_item.ts = ts_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= 16'd1;
         ts_ff    <= '0;
         left_ff  <= '0;
         bip_ff   <= '0;
         frag_ff  <= 1'b0;
         fui_ff   <= '0;
         fuh_ff   <= '0;
         limit_ff <= RST_MAX_PAYLOAD;
      end else begin
         seq_ff   <= seq_in;
         ts_ff    <= ts_in;
         left_ff  <= left_in;
         bip_ff   <= bip_in;
         frag_ff  <= frag_in;
         fui_ff   <= fui_in;
         fuh_ff   <= fuh_in;
         limit_ff <= limit_in;
      end
   end

endmodule

[rtl/rfua_cmd_queue.sv]
// short command queue between the front and back parts
// depends on rfua_pkg
module rfua_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rfua_pkg::cmd_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output rfua_pkg::cmd_type head
);
   import rfua_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

   cmd_type         entries_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CntW'(QueueDepth));
   assign valid   = (count_ff != '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/rfua_back.sv]
// back part: expands each command into output beats through an output register
// depends on rfua_pkg
module rfua_back (
   input  logic              clock,
   input  logic              reset,
   input  rfua_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  rfua_pkg::cmd_type cmd_head,
   output logic              cmd_pop,
   output logic              out_empty,
   input  logic              out_pop,
   output rfua_pkg::rsp_type out_item
);
   import rfua_pkg::*;

   logic [IdxW-1:0] idx_ff, idx_in;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_item_ff;
   logic            adv, take, data_phase;
   logic [7:0]      hdr_byte, beat_byte;

   assign adv       = !out_valid_ff || out_pop;
   assign take      = adv && cmd_valid;
   assign out_empty = !out_valid_ff;
   assign out_item  = out_item_ff;

   always_comb begin
      unique case (cmd_head.kind)
         CMD_DATA: data_phase = 1'b1;
         CMD_HDR:  data_phase = (idx_ff == IDX_HDR_DATA);
         CMD_FU:   data_phase = (idx_ff == IDX_FU_DATA);
         default:  data_phase = 1'b1;
      endcase

      unique case (idx_ff)
         4'd0:       hdr_byte = cfg.override_enable ? cfg.override_value : RTP_VERSION_BYTE;
         4'd1:       hdr_byte = cfg.override_enable ? cfg.override_value
                                                    : {cmd_head.marker, cfg.payload_type};
         4'd2:       hdr_byte = cmd_head.seq[15:8];
         4'd3:       hdr_byte = cmd_head.seq[7:0];
         4'd4:       hdr_byte = cmd_head.ts[31:24];
         4'd5:       hdr_byte = cmd_head.ts[23:16];
         4'd6:       hdr_byte = cmd_head.ts[15:8];
         4'd7:       hdr_byte = cmd_head.ts[7:0];
         4'd8:       hdr_byte = cfg.stream_source_id[31:24];
         4'd9:       hdr_byte = cfg.stream_source_id[23:16];
         4'd10:      hdr_byte = cfg.stream_source_id[15:8];
         4'd11:      hdr_byte = cfg.stream_source_id[7:0];
         IDX_FU_IND: hdr_byte = cmd_head.fu_ind;
         IDX_FU_HDR: hdr_byte = cmd_head.fu_hdr;
         default:    hdr_byte = cmd_head.data_byte;
      endcase

      beat_byte    = data_phase ? cmd_head.data_byte : hdr_byte;
      cmd_pop      = take && data_phase;
      idx_in       = idx_ff;
      if (take) begin
         idx_in = data_phase ? '0 : idx_ff + IdxW'(1);
      end
      out_valid_in = take ? 1'b1 : (out_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_item_ff.out_byte   <= beat_byte;
         out_item_ff.packet_end <= data_phase && cmd_head.pkt_end;
         out_item_ff.run_last   <= data_phase;
      end
   end

endmodule
